/* design/h264_fu_a_fragment_planner_unit_assert.svh */
// ---------------------------------------------------------------------------
// h264 fu-a fragment planner assertion macros
// concurrent assertion wrappers, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef H264_FU_A_FRAGMENT_PLANNER_UNIT_ASSERT_SVH
`define H264_FU_A_FRAGMENT_PLANNER_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define H264FU_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("h264fu assertion failed");
// next-cycle implication
`define H264FU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("h264fu assertion failed");
`else
`define H264FU_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define H264FU_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* design/h264fu_pkg.sv */
// ---------------------------------------------------------------------------
// h264fu_pkg
// shared types and constants of the fu-a fragment planner
// ---------------------------------------------------------------------------
`default_nettype none
package h264fu_pkg;

	localparam int PAYLOAD_MAX = 1400;
	localparam int MAX_RESULTS = 64;
	localparam int LEN_W       = 16;
	localparam int PLEN_W      = 11;
	localparam int CNT_W       = $clog2(MAX_RESULTS);

	localparam logic [4:0] FU_A_TYPE = 5'd28;

	typedef struct packed {
		logic [7:0]       nal_header;
		logic [LEN_W-1:0] nal_length;
	} nal_t;

	typedef struct packed {
		logic [7:0]        first_byte;
		logic [7:0]        fu_hdr;
		logic              fragmented;
		logic [LEN_W-1:0]  payload_offset;
		logic [PLEN_W-1:0] payload_length;
		logic [PLEN_W-1:0] packet_length;
		logic              last_packet;
	} pkt_t;

	// sequencer control from the top level
	typedef struct packed {
		logic start;
		logic advance;
	} seq_ctl_t;

endpackage
`default_nettype wire

/* design/h264fu_seq.sv */
// ---------------------------------------------------------------------------
// h264fu_seq
// packet sequencer: one shared subtract/compare unit steps through a nal unit
// ---------------------------------------------------------------------------
`default_nettype none
`include "h264_fu_a_fragment_planner_unit_assert.svh"
module h264fu_seq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire h264fu_pkg::seq_ctl_t ctl,
	input  wire h264fu_pkg::nal_t  item,
	output logic                   busy,
	output logic                   desc_valid,
	output h264fu_pkg::pkt_t       desc
);

	logic                                run_q;
	logic [7:0]                          hdr_q;
	logic [h264fu_pkg::LEN_W-1:0]        rem_q;
	logic [h264fu_pkg::LEN_W-1:0]        off_q;
	logic [h264fu_pkg::CNT_W-1:0]        k_q;

	logic [h264fu_pkg::PLEN_W-1:0]       cap;
	logic [h264fu_pkg::LEN_W:0]          diff;
	logic                                fits;
	logic                                first;
	logic                                lastf;
	logic [h264fu_pkg::PLEN_W-1:0]       plen;

	// shared unit: bytes left minus this packet's capacity
	always_comb begin
		first = (k_q == '0);
		cap   = first ? h264fu_pkg::PLEN_W'(h264fu_pkg::PAYLOAD_MAX - 1)
			: h264fu_pkg::PLEN_W'(h264fu_pkg::PAYLOAD_MAX);
		diff  = {1'b0, rem_q} - (h264fu_pkg::LEN_W + 1)'(cap);
		fits  = diff[h264fu_pkg::LEN_W] || (diff == '0);
		lastf = fits || (k_q == h264fu_pkg::CNT_W'(h264fu_pkg::MAX_RESULTS - 1));
		plen  = fits ? rem_q[h264fu_pkg::PLEN_W-1:0] : cap;
	end

	always_comb begin
		desc.payload_offset = off_q;
		desc.payload_length = plen;
		desc.last_packet    = lastf;
		if (first && fits) begin
			// whole unit fits one single nal unit packet
			desc.first_byte    = hdr_q;
			desc.fu_hdr        = 8'd0;
			desc.fragmented    = 1'b0;
			desc.packet_length = plen + h264fu_pkg::PLEN_W'(1);
		end else begin
			desc.first_byte    = {hdr_q[7:5], h264fu_pkg::FU_A_TYPE};
			desc.fu_hdr        = {first, lastf, 1'b0, hdr_q[4:0]};
			desc.fragmented    = 1'b1;
			desc.packet_length = plen + h264fu_pkg::PLEN_W'(2);
		end
	end

	assign busy       = run_q;
	assign desc_valid = run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else if (ctl.start) begin
			run_q <= (item.nal_length != '0);
		end else if (ctl.advance && lastf) begin
			run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			hdr_q <= item.nal_header;
			rem_q <= item.nal_length - h264fu_pkg::LEN_W'(1);
			off_q <= h264fu_pkg::LEN_W'(1);
			k_q   <= '0;
		end else if (ctl.advance && !lastf) begin
			rem_q <= diff[h264fu_pkg::LEN_W-1:0];
			off_q <= off_q + h264fu_pkg::LEN_W'(cap);
			k_q   <= k_q + h264fu_pkg::CNT_W'(1);
		end
	end

	`H264FU_ASSERT_NEXT(a_start_runs, clk, arst_n, ctl.start && (item.nal_length != '0), run_q)
	`H264FU_ASSERT_NEXT(a_count_steps, clk, arst_n, run_q && ctl.advance && !lastf, k_q == $past(k_q) + h264fu_pkg::CNT_W'(1))
	`H264FU_ASSERT_NOW(a_plen_bound, clk, arst_n, run_q, plen <= h264fu_pkg::PLEN_W'(h264fu_pkg::PAYLOAD_MAX))
	`H264FU_ASSERT_NOW(a_no_start_busy, clk, arst_n, ctl.start, !run_q)

endmodule
`default_nettype wire

/* design/h264_fu_a_fragment_planner_unit.sv */
// ---------------------------------------------------------------------------
// h264_fu_a_fragment_planner_unit
// plans rtp packets (single nal unit or fu-a fragments) for one nal unit
// ---------------------------------------------------------------------------
// usage
//  nal channel: nal_valid/nal_stall carry one nal transaction (header byte and
//   total length); the block holds nal_stall high while it is planning
//  pkt channel: pkt_valid/pkt_stall carry one packet descriptor per transaction
//  first descriptor: the nal transaction sets the sequencer's run register,
//   then the descriptor is loaded into the output register once it can take
//   one; later ones follow one per cycle while pkt is not stalled
//  the largest unit, 65535 bytes, gives 47 fragments; a zero length unit
//   gives no descriptor and never makes the block busy
//  the rate is set by the sequencer, whose single subtract/compare unit
//   yields one packet per step
//  a new nal transaction is taken while the last descriptor still waits
//   in the output register
//  reset clears the sequencer and the output valid; nothing is pending after
//  a stalled pkt holds the output register and pauses the sequencer
// ---------------------------------------------------------------------------
`default_nettype none
module h264_fu_a_fragment_planner_unit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             nal_valid,
	output logic                  nal_stall,
	input  wire h264fu_pkg::nal_t nal,
	output logic                  pkt_valid,
	input  wire logic             pkt_stall,
	output h264fu_pkg::pkt_t      pkt
);

	h264fu_pkg::seq_ctl_t ctl;
	h264fu_pkg::pkt_t     desc;
	logic                 busy;
	logic                 desc_valid;
	logic                 load_ok;
	logic                 pkt_valid_q;
	h264fu_pkg::pkt_t     pkt_q;

	// output register may take a new descriptor when empty or being drained
	assign load_ok     = !pkt_valid_q || !pkt_stall;
	assign ctl.start   = nal_valid && !busy;
	assign ctl.advance = desc_valid && load_ok;

	assign nal_stall = busy;
	assign pkt_valid = pkt_valid_q;
	assign pkt       = pkt_q;

	h264fu_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.item       (nal),
		.busy       (busy),
		.desc_valid (desc_valid),
		.desc       (desc)
	);

	// output stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_valid_q <= 1'b0;
		end else if (load_ok) begin
			pkt_valid_q <= desc_valid;
		end
	end

	// output stage payload, no reset needed
	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			pkt_q <= desc;
		end
	end

endmodule
`default_nettype wire

/* tb/sv/tb_h264_fu_a_fragment_planner_unit.sv */
// ---------------------------------------------------------------------------
// tb_h264_fu_a_fragment_planner_unit
// self-checking bench for the fu-a fragment planner: a short table of nal
// units (empty, tiny, payload limit, fragment boundaries, largest length)
// then randomised units with idle bursts on both channels; every packet
// descriptor is compared field by field against its table row or an in-bench planner
// ---------------------------------------------------------------------------
`default_nettype none
module tb_h264_fu_a_fragment_planner_unit;

	localparam int N_DIR       = 20;
	localparam int N_RANDOM    = 350;
	localparam int TAIL_ITEMS  = 50;
	localparam int CYCLE_LIMIT = 400000;
	localparam h264fu_pkg::pkt_t NO_PKT = '0;

	// one row of the directed table; typed rows carry their own expectation
	typedef struct {
		h264fu_pkg::nal_t nal;
		bit               typed;
		bit               silent; // typed row that must give no descriptor at all
		h264fu_pkg::pkt_t pkt;
	} nal_row_t;

	logic             clk;
	logic             arst_n;
	logic             nal_valid;
	logic             nal_stall;
	h264fu_pkg::nal_t nal;
	logic             pkt_valid;
	logic             pkt_stall;
	h264fu_pkg::pkt_t pkt;

	// row info travelling alongside the nal payload
	logic             drive_typed;
	logic             drive_silent;
	h264fu_pkg::pkt_t drive_pkt;

	h264fu_pkg::pkt_t pkt_expect_q[$];
	int               fail_count;
	int               cycle_count;

	// idling control: per-segment switches and a calm tail
	bit tx_idle_on;
	bit rx_idle_on;
	bit tail_calm;

	// directed table: rows with a typed result are the ones that read off at once
	nal_row_t dir_rows [N_DIR] = '{
		'{h264fu_pkg::nal_t'({8'h65, 16'd0}),     1'b1, 1'b1, NO_PKT},
		'{h264fu_pkg::nal_t'({8'h00, 16'd1}),     1'b1, 1'b0,
			h264fu_pkg::pkt_t'({8'h00, 8'h00, 1'b0, 16'd1, 11'd0, 11'd1, 1'b1})},
		'{h264fu_pkg::nal_t'({8'hFF, 16'd1}),     1'b1, 1'b0,
			h264fu_pkg::pkt_t'({8'hFF, 8'h00, 1'b0, 16'd1, 11'd0, 11'd1, 1'b1})},
		'{h264fu_pkg::nal_t'({8'h67, 16'd2}),     1'b1, 1'b0,
			h264fu_pkg::pkt_t'({8'h67, 8'h00, 1'b0, 16'd1, 11'd1, 11'd2, 1'b1})},
		'{h264fu_pkg::nal_t'({8'hFF, 16'd1400}),  1'b1, 1'b0,
			h264fu_pkg::pkt_t'({8'hFF, 8'h00, 1'b0, 16'd1, 11'd1399, 11'd1400, 1'b1})},
		'{h264fu_pkg::nal_t'({8'h1F, 16'd1399}),  1'b1, 1'b0,
			h264fu_pkg::pkt_t'({8'h1F, 8'h00, 1'b0, 16'd1, 11'd1398, 11'd1399, 1'b1})},
		'{h264fu_pkg::nal_t'({8'h65, 16'd1401}),  1'b0, 1'b0, NO_PKT},
		'{h264fu_pkg::nal_t'({8'hFC, 16'd1401}),  1'b0, 1'b0, NO_PKT},
		'{h264fu_pkg::nal_t'({8'h41, 16'd2800}),  1'b0, 1'b0, NO_PKT},
		'{h264fu_pkg::nal_t'({8'h25, 16'd2801}),  1'b0, 1'b0, NO_PKT},
		'{h264fu_pkg::nal_t'({8'hFF, 16'hFFFF}),  1'b0, 1'b0, NO_PKT},
		'{h264fu_pkg::nal_t'({8'h00, 16'hFFFF}),  1'b0, 1'b0, NO_PKT},
		'{h264fu_pkg::nal_t'({8'h9C, 16'h8000}),  1'b0, 1'b0, NO_PKT},
		'{h264fu_pkg::nal_t'({8'h7C, 16'h5555}),  1'b0, 1'b0, NO_PKT},
		'{h264fu_pkg::nal_t'({8'hAA, 16'h2AAA}),  1'b0, 1'b0, NO_PKT},
		'{h264fu_pkg::nal_t'({8'h80, 16'd0}),     1'b1, 1'b1, NO_PKT},
		'{h264fu_pkg::nal_t'({8'h01, 16'hFFFE}),  1'b0, 1'b0, NO_PKT},
		'{h264fu_pkg::nal_t'({8'hE0, 16'd4200}),  1'b0, 1'b0, NO_PKT},
		'{h264fu_pkg::nal_t'({8'h3F, 16'd4201}),  1'b0, 1'b0, NO_PKT},
		'{h264fu_pkg::nal_t'({8'h5C, 16'd700}),   1'b1, 1'b0,
			h264fu_pkg::pkt_t'({8'h5C, 8'h00, 1'b0, 16'd1, 11'd699, 11'd700, 1'b1})}
	};

	h264_fu_a_fragment_planner_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.nal_valid (nal_valid),
		.nal_stall (nal_stall),
		.nal       (nal),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.pkt       (pkt)
	);

	// 10 unit clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// packet planner: queues every descriptor one nal unit should give
	function automatic void plan_packets(input h264fu_pkg::nal_t unit);
		int               len;
		int               lo;
		int               hi;
		int               k;
		bit               fin;
		h264fu_pkg::pkt_t p;
		len = unit.nal_length;
		p   = '0;
		// empty unit: nothing goes out
		if (len == 0)
			return;
		// fits the payload limit: one single nal unit packet, header kept
		if (len <= h264fu_pkg::PAYLOAD_MAX) begin
			p.first_byte     = unit.nal_header;
			p.fu_hdr         = 8'h00;
			p.fragmented     = 1'b0;
			p.payload_offset = h264fu_pkg::LEN_W'(1);
			p.payload_length = h264fu_pkg::PLEN_W'(len - 1);
			p.packet_length  = h264fu_pkg::PLEN_W'(len);
			p.last_packet    = 1'b1;
			pkt_expect_q.push_back(p);
			return;
		end
		// fu-a: fragment 0 starts after the header byte, others on multiples
		for (k = 0; k < h264fu_pkg::MAX_RESULTS; k++) begin
			lo  = (k == 0) ? 1 : k * h264fu_pkg::PAYLOAD_MAX;
			hi  = (k + 1) * h264fu_pkg::PAYLOAD_MAX;
			fin = (hi >= len) || (k == h264fu_pkg::MAX_RESULTS - 1);
			if (hi > len)
				hi = len;
			if (hi < lo)
				hi = lo;
			p.first_byte     = {unit.nal_header[7:5], h264fu_pkg::FU_A_TYPE};
			p.fu_hdr         = {(k == 0), fin, 1'b0, unit.nal_header[4:0]};
			p.fragmented     = 1'b1;
			p.payload_offset = h264fu_pkg::LEN_W'(lo);
			p.payload_length = h264fu_pkg::PLEN_W'(hi - lo);
			p.packet_length  = h264fu_pkg::PLEN_W'(hi - lo + 2);
			p.last_packet    = fin;
			pkt_expect_q.push_back(p);
			if (fin)
				break;
		end
	endfunction

	// offer one nal transaction from the falling edge and hold it until taken
	task automatic send_nal(input h264fu_pkg::nal_t unit, input bit typed,
	                        input bit silent, input h264fu_pkg::pkt_t want);
		@(negedge clk);
		nal          <= unit;
		nal_valid    <= 1'b1;
		drive_typed  <= typed;
		drive_silent <= silent;
		drive_pkt    <= want;
		do @(posedge clk); while (nal_stall !== 1'b0);
	endtask

	// idle burst on the sender: valid held low
	task automatic sender_gap();
		int n;
		n = $urandom_range(1, 5);
		@(negedge clk);
		nal_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// scoreboard: sampled at the rising edge, before the block updates.
	// descriptor check runs ahead of the push so a descriptor of the unit
	// accepted in the same cycle can never be matched by mistake
	always @(posedge clk) begin
		h264fu_pkg::pkt_t want;
		if (arst_n) begin
			if (pkt_valid === 1'b1 && pkt_stall === 1'b0) begin
				if (pkt_expect_q.size() == 0) begin
					$error("unexpected packet transaction: %h", pkt);
					fail_count++;
				end else begin
					want = pkt_expect_q.pop_front();
					if (pkt.first_byte !== want.first_byte) begin
						$error("first_byte: expected %0h, got %0h",
						       want.first_byte, pkt.first_byte);
						fail_count++;
					end
					if (pkt.fu_hdr !== want.fu_hdr) begin
						$error("fu_hdr: expected %0h, got %0h",
						       want.fu_hdr, pkt.fu_hdr);
						fail_count++;
					end
					if (pkt.fragmented !== want.fragmented) begin
						$error("fragmented: expected %0d, got %0d",
						       want.fragmented, pkt.fragmented);
						fail_count++;
					end
					if (pkt.payload_offset !== want.payload_offset) begin
						$error("payload_offset: expected %0d, got %0d",
						       want.payload_offset, pkt.payload_offset);
						fail_count++;
					end
					if (pkt.payload_length !== want.payload_length) begin
						$error("payload_length: expected %0d, got %0d",
						       want.payload_length, pkt.payload_length);
						fail_count++;
					end
					if (pkt.packet_length !== want.packet_length) begin
						$error("packet_length: expected %0d, got %0d",
						       want.packet_length, pkt.packet_length);
						fail_count++;
					end
					if (pkt.last_packet !== want.last_packet) begin
						$error("last_packet: expected %0d, got %0d",
						       want.last_packet, pkt.last_packet);
						fail_count++;
					end
				end
			end
			// accepted nal transaction: typed rows bring their own answer
			if (nal_valid === 1'b1 && nal_stall === 1'b0) begin
				if (drive_typed) begin
					if (!drive_silent)
						pkt_expect_q.push_back(drive_pkt);
				end else begin
					plan_packets(nal);
				end
			end
		end
	end

	// receiver back-pressure: stall bursts while idling is on, none in the tail
	initial begin
		pkt_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!tail_calm && rx_idle_on && $urandom_range(0, 3) == 0) begin
				pkt_stall <= 1'b1;
				repeat ($urandom_range(0, 4)) @(negedge clk);
			end else begin
				pkt_stall <= 1'b0;
			end
		end
	end

	// watchdog: a hang or a missing descriptor ends here
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	// main sequence
	initial begin
		h264fu_pkg::nal_t unit;
		int               len;
		int               k;
		int               i;
		int               w;
		clk          = 1'b0;
		arst_n       = 1'b0;
		nal_valid    = 1'b0;
		nal          = '0;
		drive_typed  = 1'b0;
		drive_silent = 1'b0;
		drive_pkt    = '0;
		fail_count   = 0;
		tx_idle_on   = 1'b0;
		rx_idle_on   = 1'b0;
		tail_calm    = 1'b0;

		// reset held low at start, released away from the rising edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table, back to back with the receiver always ready
		for (i = 0; i < N_DIR; i++)
			send_nal(dir_rows[i].nal, dir_rows[i].typed, dir_rows[i].silent,
			         dir_rows[i].pkt);

		// sender holds off until the block has drained every descriptor
		@(negedge clk);
		nal_valid <= 1'b0;
		while (pkt_expect_q.size() != 0)
			@(posedge clk);

		// randomised units; idling switched per segment, calm tail at the end
		for (i = 0; i < N_RANDOM; i++) begin
			if (i % 50 == 0) begin
				tx_idle_on = ($urandom_range(0, 3) != 0);
				rx_idle_on = ($urandom_range(0, 3) != 0);
			end
			if (i == N_RANDOM - TAIL_ITEMS)
				tail_calm = 1'b1;

			unit.nal_header = 8'($urandom_range(0, 255));
			case ($urandom_range(0, 9))
				0, 1, 2, 3: len = $urandom_range(0, h264fu_pkg::PAYLOAD_MAX);
				4:          len = $urandom_range(0, 3);
				5, 6: begin
					// straddle a fragment boundary
					k   = $urandom_range(1, 46);
					len = k * h264fu_pkg::PAYLOAD_MAX + $urandom_range(0, 2) - 1;
				end
				7:          len = $urandom_range(h264fu_pkg::PAYLOAD_MAX + 1, 8000);
				8:          len = $urandom_range(0, 65535);
				default:    len = $urandom_range(65000, 65535);
			endcase
			unit.nal_length = h264fu_pkg::LEN_W'(len);

			if (!tail_calm && tx_idle_on && $urandom_range(0, 2) == 0)
				sender_gap();
			send_nal(unit, 1'b0, 1'b0, NO_PKT);
		end

		@(negedge clk);
		nal_valid <= 1'b0;

		// drain, then keep watching to catch any stray descriptor
		for (w = 0; w < 5000 && pkt_expect_q.size() != 0; w++)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (pkt_expect_q.size() != 0) begin
			$error("%0d packet descriptors never arrived", pkt_expect_q.size());
			fail_count++;
		end

		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire

/* sim.f */
+incdir+design
design/h264fu_pkg.sv
design/h264fu_seq.sv
design/h264_fu_a_fragment_planner_unit.sv
tb/sv/tb_h264_fu_a_fragment_planner_unit.sv
